// ===== hw/rtl/hotp_pkg.sv =====
// Package for the HOTP code generator: state and phase types, register indexes,
// SHA-1 constants, the truncation limit and the small tables used by the reduction logic.
// Depends on nothing; hotp_reduce and hotp_code_generator use it.
package hotp_pkg;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_HASH   = 6'b000100,
		ST_TRUNC  = 6'b001000,
		ST_REDUCE = 6'b010000,
		ST_FIN    = 6'b100000
	} hotp_state_t;

	typedef enum logic [4:0] {
		RD_IDLE = 5'b00001,
		RD_DIV  = 5'b00010,
		RD_MUL  = 5'b00100,
		RD_SUB  = 5'b01000,
		RD_FIN  = 5'b10000
	} hotp_rd_state_t;

	typedef enum logic [1:0] {
		PH_IN_KEY  = 2'd0,
		PH_IN_MSG  = 2'd1,
		PH_OUT_KEY = 2'd2,
		PH_OUT_MSG = 2'd3
	} hotp_phase_t;

	typedef enum logic [1:0] {
		REG_DIGIT_COUNT  = 2'd0,
		REG_TRUNC_OFFSET = 2'd1,
		REG_CHECK_ENABLE = 2'd2,
		REG_KEY_LENGTH   = 2'd3
	} hotp_reg_t;

	localparam logic [159:0] SHA1_IV =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5C;
	localparam logic [63:0] INNER_BITS = 64'd576;
	localparam logic [63:0] OUTER_BITS = 64'd672;
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam logic [3:0] MAX_DIGITS = 4'd8;
	localparam logic [4:0] MAX_FIXED_OFFSET = 5'd16;

	function automatic logic [26:0] pow10(input logic [3:0] d);
		logic [26:0] r;
		unique case (d)
			4'd1: r = 27'd10;
			4'd2: r = 27'd100;
			4'd3: r = 27'd1000;
			4'd4: r = 27'd10000;
			4'd5: r = 27'd100000;
			4'd6: r = 27'd1000000;
			4'd7: r = 27'd10000000;
			4'd8: r = 27'd100000000;
			default: r = 27'd1;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] luhn_double(input logic [3:0] dg);
		logic [3:0] r;
		unique case (dg)
			4'd1: r = 4'd2;
			4'd2: r = 4'd4;
			4'd3: r = 4'd6;
			4'd4: r = 4'd8;
			4'd5: r = 4'd1;
			4'd6: r = 4'd3;
			4'd7: r = 4'd5;
			4'd8: r = 4'd7;
			4'd9: r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/hotp_sha1_core.sv =====
// Iterative SHA-1 compression: one round per cycle over a 16-word schedule window,
// then a final step for the chaining add. Takes one 512-bit block per start pulse.
// Depends on nothing.
module hotp_sha1_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [159:0] h_in,
	input  logic [511:0] blk,
	output logic         done,
	output logic [159:0] h_out
);

	logic         busy_q;
	logic [6:0]   rnd_q;
	logic         done_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q;
	logic [159:0] hout_q;
	logic [31:0]  w_q [16];
	logic [31:0]  f, k, t, w_new, w_mix;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_mix[30:0], w_mix[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (rnd_q == 7'd80);
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd80) begin
					busy_q <= 1'b0;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= h_in;
			a_q <= h_in[159:128];
			b_q <= h_in[127:96];
			c_q <= h_in[95:64];
			d_q <= h_in[63:32];
			e_q <= h_in[31:0];
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511 - 32 * i -: 32];
			end
		end else if (busy_q) begin
			if (rnd_q == 7'd80) begin
				hout_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
					h_q[63:32] + d_q, h_q[31:0] + e_q};
			end else begin
				a_q <= t;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= w_new;
			end
		end
	end

	assign done  = done_q;
	assign h_out = hout_q;

endmodule

// ===== hw/rtl/hotp_reduce.sv =====
// Iterative reduction of the truncated hash value modulo a power of ten by
// shift-and-subtract, optionally followed by a digit-at-a-time check digit computation.
// Depends on hotp_pkg.
module hotp_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] bin,
	input  logic [3:0]  digit_count,
	input  logic        check_enable,
	output logic        done,
	output logic [29:0] code
);

	hotp_pkg::hotp_rd_state_t st_q;
	logic [30:0] r_q;
	logic [57:0] msh_q;
	logic [4:0]  k_q;
	logic [26:0] num_q;
	logic [26:0] otp_q;
	logic [58:0] prod_q;
	logic [6:0]  tot_q;
	logic        dbl_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [29:0] code_q;

	logic        ge;
	logic [30:0] r_nx;
	logic [58:0] prod;
	logic [23:0] q;
	logic [26:0] q10;
	logic [3:0]  dg;
	logic [3:0]  add;
	logic [14:0] tmp;
	logic [3:0]  q2;
	logic [3:0]  rem;
	logic [3:0]  chk;
	logic [29:0] fin_code;

	always_comb begin
		ge   = (msh_q[57:31] == '0) && (r_q >= msh_q[30:0]);
		r_nx = ge ? r_q - msh_q[30:0] : r_q;
		prod = num_q * hotp_pkg::RECIP10;
		q    = prod_q[58:35];
		q10  = {q, 3'b000} + {2'b00, q, 1'b0};
		dg   = num_q[3:0] - q10[3:0];
		add  = dbl_q ? hotp_pkg::luhn_double(dg) : dg;
		tmp  = 15'(tot_q) * 15'd205;
		q2   = tmp[14:11];
		rem  = tot_q[3:0] - 4'({q2, 3'b000} + {q2, 1'b0});
		chk  = (rem != 4'd0) ? 4'd10 - rem : 4'd0;
		fin_code = {otp_q, 3'b000} + {2'b00, otp_q, 1'b0} + 30'(chk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= hotp_pkg::RD_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= ((st_q == hotp_pkg::RD_DIV) && (k_q == 5'd0) && !check_enable)
				|| (st_q == hotp_pkg::RD_FIN);
			unique case (st_q)
				hotp_pkg::RD_IDLE: begin
					if (start) begin
						st_q <= hotp_pkg::RD_DIV;
					end
				end
				hotp_pkg::RD_DIV: begin
					if (k_q == 5'd0) begin
						if (check_enable) begin
							st_q <= hotp_pkg::RD_MUL;
						end else begin
							st_q <= hotp_pkg::RD_IDLE;
						end
					end
				end
				hotp_pkg::RD_MUL: st_q <= hotp_pkg::RD_SUB;
				hotp_pkg::RD_SUB: begin
					if (cnt_q == digit_count - 4'd1) begin
						st_q <= hotp_pkg::RD_FIN;
					end else begin
						st_q <= hotp_pkg::RD_MUL;
					end
				end
				hotp_pkg::RD_FIN: st_q <= hotp_pkg::RD_IDLE;
				default: st_q <= hotp_pkg::RD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			hotp_pkg::RD_IDLE: begin
				r_q   <= bin;
				msh_q <= {1'b0, hotp_pkg::pow10(digit_count), 30'd0};
				k_q   <= 5'd30;
			end
			hotp_pkg::RD_DIV: begin
				r_q   <= r_nx;
				msh_q <= msh_q >> 1;
				k_q   <= k_q - 5'd1;
				num_q <= r_nx[26:0];
				otp_q <= r_nx[26:0];
				tot_q <= '0;
				dbl_q <= 1'b1;
				cnt_q <= '0;
				code_q <= 30'(r_nx);
			end
			hotp_pkg::RD_MUL: prod_q <= prod;
			hotp_pkg::RD_SUB: begin
				tot_q <= tot_q + 7'(add);
				dbl_q <= ~dbl_q;
				num_q <= 27'(q);
				cnt_q <= cnt_q + 4'd1;
			end
			hotp_pkg::RD_FIN: code_q <= fin_code;
			default: code_q <= code_q;
		endcase
	end

	assign done = done_q;
	assign code = code_q;

endmodule

// ===== hw/rtl/hotp_code_generator.sv =====
// HOTP code generator top level: key store, configuration registers, sequencer,
// truncation and output register. Depends on hotp_pkg, hotp_sha1_core and hotp_reduce.
//
// A key-write item is written into the key store as it is accepted. A generate item
// reads the key store one byte per cycle through its single read port, then runs four
// SHA-1 compressions on the shared round unit (start, 80 rounds, chaining add, handoff),
// one truncation step, 31 shift-and-subtract steps for the modulo and then the handoff
// and output; with the check digit enabled, a multiply and a subtract step per code
// digit plus a final step are added. The input is not ready while a code is in work;
// a finished code waits in the output register while the next item is taken. Items
// with an invalid configuration give no code.
module hotp_code_generator #(
	parameter int MAX_KEY_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [5:0]  key_index,
	input  logic [7:0]  key_byte,
	input  logic [62:0] counter_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [29:0] code,
	input  logic        write_enable,
	input  logic [1:0]  write_index,
	input  logic [6:0]  write_data
);

	localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

	hotp_pkg::hotp_state_t st_q;
	hotp_pkg::hotp_phase_t phase_q;

	logic [3:0]   digit_count_q;
	logic [5:0]   trunc_offset_q;
	logic         check_enable_q;
	logic [6:0]   key_length_q;

	logic [7:0]   mem [MAX_KEY_BYTES];
	logic [7:0]   rdata_s1;
	logic         vld_s1;
	logic         use_s1;
	logic [6:0]   cnt_q;
	logic [511:0] key_blk_q;
	logic [62:0]  ctr_q;
	logic [159:0] chain_q;
	logic [159:0] inner_q;
	logic [30:0]  bin_q;
	logic [29:0]  res_q;
	logic         sha_start_q;
	logic         red_start_q;
	logic         out_valid_q;
	logic [29:0]  code_q;

	logic         accept;
	logic         mem_we;
	logic         cfg_ok;
	logic         fin_load;
	logic [159:0] h_in;
	logic [511:0] blk;
	logic         sha_done;
	logic [159:0] h_out;
	logic         red_done;
	logic [29:0]  red_code;
	logic [4:0]   off;
	logic [159:0] sh;

	assign in_ready = (st_q == hotp_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign mem_we   = accept && !mode && (7'(key_index) < 7'(MAX_KEY_BYTES));
	assign cfg_ok   = (digit_count_q >= 4'd1) && (digit_count_q <= hotp_pkg::MAX_DIGITS)
		&& (key_length_q >= 7'd1) && (key_length_q <= 7'(MAX_KEY_BYTES))
		&& (trunc_offset_q[5] || (trunc_offset_q[4:0] <= hotp_pkg::MAX_FIXED_OFFSET));
	assign fin_load = (st_q == hotp_pkg::ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q  <= 4'd6;
			trunc_offset_q <= 6'h3F;
			check_enable_q <= 1'b0;
			key_length_q   <= 7'd20;
		end else if (write_enable) begin
			unique case (write_index)
				hotp_pkg::REG_DIGIT_COUNT:  digit_count_q  <= write_data[3:0];
				hotp_pkg::REG_TRUNC_OFFSET: trunc_offset_q <= write_data[5:0];
				hotp_pkg::REG_CHECK_ENABLE: check_enable_q <= write_data[0];
				hotp_pkg::REG_KEY_LENGTH:   key_length_q   <= write_data;
				default: key_length_q <= key_length_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[key_index[AW-1:0]] <= key_byte;
		end
		rdata_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_comb begin
		unique case (phase_q)
			hotp_pkg::PH_IN_KEY: begin
				h_in = hotp_pkg::SHA1_IV;
				blk  = key_blk_q ^ {64{hotp_pkg::IPAD}};
			end
			hotp_pkg::PH_IN_MSG: begin
				h_in = chain_q;
				blk  = {1'b0, ctr_q, 8'h80, 376'd0, hotp_pkg::INNER_BITS};
			end
			hotp_pkg::PH_OUT_KEY: begin
				h_in = hotp_pkg::SHA1_IV;
				blk  = key_blk_q ^ {64{hotp_pkg::OPAD}};
			end
			hotp_pkg::PH_OUT_MSG: begin
				h_in = chain_q;
				blk  = {inner_q, 8'h80, 280'd0, hotp_pkg::OUTER_BITS};
			end
			default: begin
				h_in = chain_q;
				blk  = key_blk_q;
			end
		endcase
		off = trunc_offset_q[5] ? {1'b0, h_out[3:0]} : trunc_offset_q[4:0];
		sh  = h_out << {off, 3'b000};
	end

	hotp_sha1_core u_sha1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start_q),
		.h_in   (h_in),
		.blk    (blk),
		.done   (sha_done),
		.h_out  (h_out)
	);

	hotp_reduce u_reduce (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (red_start_q),
		.bin          (bin_q),
		.digit_count  (digit_count_q),
		.check_enable (check_enable_q),
		.done         (red_done),
		.code         (red_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= hotp_pkg::ST_IDLE;
			phase_q     <= hotp_pkg::PH_IN_KEY;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			use_s1      <= 1'b0;
			sha_start_q <= 1'b0;
			red_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sha_start_q <= ((st_q == hotp_pkg::ST_LOAD) && (cnt_q == 7'd64))
				|| ((st_q == hotp_pkg::ST_HASH) && sha_done
				&& (phase_q != hotp_pkg::PH_OUT_MSG));
			red_start_q <= (st_q == hotp_pkg::ST_TRUNC);
			vld_s1      <= (st_q == hotp_pkg::ST_LOAD) && (cnt_q != 7'd64);
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				hotp_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept && mode && cfg_ok) begin
						st_q <= hotp_pkg::ST_LOAD;
					end
				end
				hotp_pkg::ST_LOAD: begin
					if (cnt_q == 7'd64) begin
						st_q    <= hotp_pkg::ST_HASH;
						phase_q <= hotp_pkg::PH_IN_KEY;
					end else begin
						use_s1 <= (cnt_q < key_length_q) && (cnt_q < 7'(MAX_KEY_BYTES));
						cnt_q  <= cnt_q + 7'd1;
					end
				end
				hotp_pkg::ST_HASH: begin
					if (sha_done) begin
						unique case (phase_q)
							hotp_pkg::PH_IN_KEY:  phase_q <= hotp_pkg::PH_IN_MSG;
							hotp_pkg::PH_IN_MSG:  phase_q <= hotp_pkg::PH_OUT_KEY;
							hotp_pkg::PH_OUT_KEY: phase_q <= hotp_pkg::PH_OUT_MSG;
							hotp_pkg::PH_OUT_MSG: st_q <= hotp_pkg::ST_TRUNC;
							default: st_q <= hotp_pkg::ST_IDLE;
						endcase
					end
				end
				hotp_pkg::ST_TRUNC: st_q <= hotp_pkg::ST_REDUCE;
				hotp_pkg::ST_REDUCE: begin
					if (red_done) begin
						st_q <= hotp_pkg::ST_FIN;
					end
				end
				hotp_pkg::ST_FIN: begin
					if (fin_load) begin
						st_q <= hotp_pkg::ST_IDLE;
					end
				end
				default: st_q <= hotp_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctr_q <= counter_value;
		end
		if (vld_s1) begin
			key_blk_q <= {key_blk_q[503:0], use_s1 ? rdata_s1 : 8'h00};
		end
		if (sha_done) begin
			if (phase_q == hotp_pkg::PH_IN_MSG) begin
				inner_q <= h_out;
			end else begin
				chain_q <= h_out;
			end
		end
		if (st_q == hotp_pkg::ST_TRUNC) begin
			bin_q <= sh[158:128];
		end
		if (red_done) begin
			res_q <= red_code;
		end
		if (fin_load) begin
			code_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign code      = code_q;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == hotp_pkg::ST_LOAD) |-> !in_ready)
		else $error("input ready while the key store is being read");

	a_sha_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		sha_done |-> (st_q == hotp_pkg::ST_HASH))
		else $error("hash completion outside the hash phase");

	a_red_done_in_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		red_done |-> (st_q == hotp_pkg::ST_REDUCE))
		else $error("reduction completion outside the reduce phase");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == hotp_pkg::ST_FIN))
		else $error("result item raised without a finished code");

endmodule
